@@ sv/ascon_pkg.sv @@
// Shared types and constants for the Ascon permutation unit.
package ascon_pkg;

  localparam int unsigned TotalRounds = 12;
  localparam int unsigned RoundIdxW   = $clog2(TotalRounds);

  typedef logic [RoundIdxW-1:0] round_idx_t;

  localparam logic [7:0] RoundConst [TotalRounds] = '{
    8'hf0, 8'he1, 8'hd2, 8'hc3, 8'hb4, 8'ha5,
    8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b
  };

  typedef struct packed {
    logic [63:0] word_0;
    logic [63:0] word_1;
    logic [63:0] word_2;
    logic [63:0] word_3;
    logic [63:0] word_4;
    logic [3:0]  round_count;
  } in_word_t;

  typedef struct packed {
    logic [63:0] out_word_0;
    logic [63:0] out_word_1;
    logic [63:0] out_word_2;
    logic [63:0] out_word_3;
    logic [63:0] out_word_4;
  } out_word_t;

  typedef struct packed {
    logic       load;
    logic       round_en;
    round_idx_t round_idx;
    logic       out_load;
  } dp_cmd_t;

endpackage

@@ sv/ascon_dp.sv @@
// Datapath: state register, shared round unit and output register.
module ascon_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ascon_pkg::dp_cmd_t  cmd_i,
  input  ascon_pkg::in_word_t in_word_i,
  output ascon_pkg::out_word_t out_word_o
);

  logic [63:0] s_q [5];
  logic [63:0] s_d [5];
  logic [63:0] r_out [5];
  ascon_pkg::out_word_t out_q;

  function automatic logic [63:0] rotr(logic [63:0] v, int unsigned n);
    rotr = (v >> n) | (v << (64 - n));
  endfunction

  always_comb begin
    logic [63:0] a0, a1, a2, a3, a4;
    logic [63:0] n0, n1, n2, n3, n4;
    a0 = s_q[0];
    a1 = s_q[1];
    a2 = s_q[2] ^ {56'd0, ascon_pkg::RoundConst[cmd_i.round_idx]};
    a3 = s_q[3];
    a4 = s_q[4];
    a0 = a0 ^ a4;
    a4 = a4 ^ a3;
    a2 = a2 ^ a1;
    n0 = ~a0 & a1;
    n1 = ~a1 & a2;
    n2 = ~a2 & a3;
    n3 = ~a3 & a4;
    n4 = ~a4 & a0;
    a0 = a0 ^ n1;
    a1 = a1 ^ n2;
    a2 = a2 ^ n3;
    a3 = a3 ^ n4;
    a4 = a4 ^ n0;
    a1 = a1 ^ a0;
    a0 = a0 ^ a4;
    a3 = a3 ^ a2;
    a2 = ~a2;
    r_out[0] = a0 ^ rotr(a0, 19) ^ rotr(a0, 28);
    r_out[1] = a1 ^ rotr(a1, 61) ^ rotr(a1, 39);
    r_out[2] = a2 ^ rotr(a2, 1)  ^ rotr(a2, 6);
    r_out[3] = a3 ^ rotr(a3, 10) ^ rotr(a3, 17);
    r_out[4] = a4 ^ rotr(a4, 7)  ^ rotr(a4, 41);
  end

  always_comb begin
    s_d = s_q;
    if (cmd_i.load) begin
      s_d[0] = in_word_i.word_0;
      s_d[1] = in_word_i.word_1;
      s_d[2] = in_word_i.word_2;
      s_d[3] = in_word_i.word_3;
      s_d[4] = in_word_i.word_4;
    end else if (cmd_i.round_en) begin
      s_d = r_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q   <= '{default: '0};
      out_q <= '0;
    end else begin
      s_q <= s_d;
      if (cmd_i.out_load) begin
        out_q.out_word_0 <= s_q[0];
        out_q.out_word_1 <= s_q[1];
        out_q.out_word_2 <= s_q[2];
        out_q.out_word_3 <= s_q[3];
        out_q.out_word_4 <= s_q[4];
      end
    end
  end

  assign out_word_o = out_q;

endmodule

@@ sv/ascon_ctrl.sv @@
// Controller: round sequencing and output handshake.
module ascon_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         round_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ascon_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StRun   = 3'b010,
    StFlush = 3'b100
  } state_e;

  state_e                state_q, state_d;
  ascon_pkg::round_idx_t round_q, round_d;
  logic                  out_valid_q, out_valid_d;

  localparam ascon_pkg::round_idx_t LastRound =
    ascon_pkg::round_idx_t'(ascon_pkg::TotalRounds - 1);
  localparam logic [3:0] MaxCount = 4'(ascon_pkg::TotalRounds);

  logic [3:0] count_clamped;
  logic       out_free;

  assign count_clamped = (round_count_i > MaxCount) ? MaxCount : round_count_i;
  assign out_free      = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    round_d        = round_q;
    out_valid_d    = out_valid_q;
    cmd_o          = '0;
    cmd_o.round_idx = round_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          round_d    = ascon_pkg::round_idx_t'(MaxCount - count_clamped);
          state_d    = (count_clamped == 4'd0) ? StFlush : StRun;
        end
      end
      StRun: begin
        cmd_o.round_en = 1'b1;
        round_d        = round_q + 1'b1;
        if (round_q == LastRound) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

@@ sv/ascon_permutation_unit.sv @@
// Top level of the Ascon permutation unit.
// Applies the last round_count rounds (clamped to 12) of the Ascon p permutation to a
// 320-bit state word. One shared round unit runs one round per cycle. A word passes
// through an acceptance step that loads the state, the rounds, and a flush step that
// moves the state into the output register.
// A new word is taken while the previous result waits in the output register; the next
// finished state then waits until that result is taken.
module ascon_permutation_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ascon_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ascon_pkg::out_word_t out_word_o
);

  ascon_pkg::dp_cmd_t cmd;

  ascon_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .round_count_i(in_word_i.round_count),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd)
  );

  ascon_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_word_i (in_word_i),
    .out_word_o(out_word_o)
  );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the Ascon permutation unit: directed and random words with stalls on both sides.
module tb_top;

  localparam int unsigned NumRandom = 1700;
  localparam int unsigned DrainAt   = 1000;
  localparam int unsigned HoldAt    = 300;
  localparam int unsigned HoldLen   = 500;
  localparam int unsigned IdleLimit = 5000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  ascon_pkg::in_word_t  in_word_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  ascon_pkg::out_word_t out_word_o;

  ascon_pkg::in_word_t  stim_q[$];
  ascon_pkg::out_word_t pending_states_q[$];
  int unsigned driven_cnt = 0;
  int unsigned acc_cnt = 0;
  int unsigned rcvd_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned stall_cnt = 0;
  int unsigned hold_cnt = 0;
  bit          hold_done = 1'b0;
  int unsigned idle_cycles = 0;

  ascon_permutation_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] rotr(logic [63:0] v, int unsigned n);
    return (v >> n) | (v << (64 - n));
  endfunction

  // last round_count rounds of Ascon p, counts above 12 clamped
  function automatic ascon_pkg::out_word_t ascon_p(ascon_pkg::in_word_t w);
    logic [63:0] x0, x1, x2, x3, x4;
    logic [63:0] t0, t1, t2, t3, t4;
    logic [3:0]  rc_hi, rc_lo;
    int unsigned nrounds;
    ascon_pkg::out_word_t res;
    x0 = w.word_0;
    x1 = w.word_1;
    x2 = w.word_2;
    x3 = w.word_3;
    x4 = w.word_4;
    nrounds = (w.round_count > 4'd12) ? 12 : int'(w.round_count);
    for (int r = 12 - nrounds; r < 12; r++) begin
      rc_hi = 4'(15 - r);
      rc_lo = 4'(r);
      x2 = x2 ^ {56'd0, rc_hi, rc_lo};
      x0 = x0 ^ x4;
      x4 = x4 ^ x3;
      x2 = x2 ^ x1;
      t0 = ~x0 & x1;
      t1 = ~x1 & x2;
      t2 = ~x2 & x3;
      t3 = ~x3 & x4;
      t4 = ~x4 & x0;
      x0 = x0 ^ t1;
      x1 = x1 ^ t2;
      x2 = x2 ^ t3;
      x3 = x3 ^ t4;
      x4 = x4 ^ t0;
      x1 = x1 ^ x0;
      x0 = x0 ^ x4;
      x3 = x3 ^ x2;
      x2 = ~x2;
      x0 = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
      x1 = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
      x2 = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
      x3 = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
      x4 = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
    end
    res.out_word_0 = x0;
    res.out_word_1 = x1;
    res.out_word_2 = x2;
    res.out_word_3 = x3;
    res.out_word_4 = x4;
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 10) return 0;
    if (sel < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic ascon_pkg::in_word_t make_word(logic [63:0] w0, logic [63:0] w1,
                                                    logic [63:0] w2, logic [63:0] w3,
                                                    logic [63:0] w4, logic [3:0] cnt);
    ascon_pkg::in_word_t w;
    w.word_0 = w0;
    w.word_1 = w1;
    w.word_2 = w2;
    w.word_3 = w3;
    w.word_4 = w4;
    w.round_count = cnt;
    return w;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // sender: valid held with payload stable until accepted
  always @(negedge clk_i) begin
    logic                v_next;
    ascon_pkg::in_word_t w_next;
    if (rst_ni) begin
      v_next = in_valid_i;
      w_next = in_word_i;
      if (in_valid_i && acc_cnt == driven_cnt) v_next = 1'b0;
      if (!v_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (driven_cnt == DrainAt && pending_states_q.size() != 0) begin
          // pause until all results are back
        end else if (stim_q.size() != 0) begin
          w_next = stim_q.pop_front();
          v_next = 1'b1;
          driven_cnt++;
          send_gap = ((driven_cnt / 250) % 4 == 1) ? 0 : pick_gap();
        end
      end
      in_valid_i <= v_next;
      in_word_i  <= w_next;
    end
  end

  // receiver ready with random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && rcvd_cnt >= HoldAt) begin
        hold_done = 1'b1;
        hold_cnt  = HoldLen;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if ((rcvd_cnt / 250) % 4 == 2) begin
        out_ready_i <= 1'b1;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_cnt = pick_gap();
      end
    end
  end

  // result check and expectation tracking
  always @(posedge clk_i) begin
    ascon_pkg::out_word_t exp_w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        rcvd_cnt++;
        if (pending_states_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result word %h", $time, out_word_o);
        end else begin
          exp_w = pending_states_q.pop_front();
          check_field("out_word_0", exp_w.out_word_0, out_word_o.out_word_0);
          check_field("out_word_1", exp_w.out_word_1, out_word_o.out_word_1);
          check_field("out_word_2", exp_w.out_word_2, out_word_o.out_word_2);
          check_field("out_word_3", exp_w.out_word_3, out_word_o.out_word_3);
          check_field("out_word_4", exp_w.out_word_4, out_word_o.out_word_4);
        end
      end
      if (in_valid_i && in_ready_o) begin
        acc_cnt++;
        pending_states_q.push_back(ascon_p(in_word_i));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout at %0t", $time);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] r0, r1, r2, r3, r4;
    // zero state through every count, including clamped ones
    for (int c = 0; c < 16; c++) begin
      stim_q.push_back(make_word('0, '0, '0, '0, '0, 4'(c)));
    end
    stim_q.push_back(make_word('1, '1, '1, '1, '1, 4'd12));
    stim_q.push_back(make_word('1, '1, '1, '1, '1, 4'd0));
    stim_q.push_back(make_word({16{4'ha}}, {16{4'h5}}, {16{4'ha}}, {16{4'h5}}, {16{4'ha}},
                               4'd12));
    stim_q.push_back(make_word({1'b1, 63'd0}, 64'd1, {1'b1, 63'd0}, 64'd1, {1'b1, 63'd0},
                               4'd1));
    r0 = rand64(); r1 = rand64(); r2 = rand64(); r3 = rand64(); r4 = rand64();
    stim_q.push_back(make_word(r0, r1, r2, r3, r4, 4'd0));
    stim_q.push_back(make_word(r0, r1, r2, r3, r4, 4'd15));
    for (int i = 0; i < NumRandom; i++) begin
      stim_q.push_back(make_word(rand64(), rand64(), rand64(), rand64(), rand64(),
                                 4'($urandom_range(0, 15))));
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (stim_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_states_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_states_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/ascon_pkg.sv
sv/ascon_dp.sv
sv/ascon_ctrl.sv
sv/ascon_permutation_unit.sv
dv/tb_top.sv
